FILE: hdl/ajr_pkg.sv
// Package: shared constants, register indexes, row codes and pipeline types.
`default_nettype none
package ajr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int N_ROWS    = 6;

	// configuration register indexes
	localparam logic [2:0] REG_SENSOR1_X  = 3'd0;
	localparam logic [2:0] REG_SENSOR1_Y  = 3'd1;
	localparam logic [2:0] REG_SENSOR2_X  = 3'd2;
	localparam logic [2:0] REG_SENSOR2_Y  = 3'd3;
	localparam logic [2:0] REG_SENSOR3_X  = 3'd4;
	localparam logic [2:0] REG_SENSOR3_Y  = 3'd5;
	localparam logic [2:0] REG_TDOA_SCALE = 3'd6;

	localparam logic signed [31:0] RST_SENSOR1_X  = 32'sd0;
	localparam logic signed [31:0] RST_SENSOR1_Y  = 32'sd0;
	localparam logic signed [31:0] RST_SENSOR2_X  = -32'sd128195;
	localparam logic signed [31:0] RST_SENSOR2_Y  = -32'sd48484149;
	localparam logic signed [31:0] RST_SENSOR3_X  = -32'sd25105256;
	localparam logic signed [31:0] RST_SENSOR3_Y  = -32'sd151179;
	localparam logic signed [31:0] RST_TDOA_SCALE = 32'sd65536;

	// full row codes
	localparam logic [2:0] ROW_AOA1   = 3'd0;
	localparam logic [2:0] ROW_AOA2   = 3'd1;
	localparam logic [2:0] ROW_AOA3   = 3'd2;
	localparam logic [2:0] ROW_TDOA12 = 3'd3;
	localparam logic [2:0] ROW_TDOA13 = 3'd4;
	localparam logic [2:0] ROW_TDOA23 = 3'd5;

	localparam logic [3:0] AOA_UNIT_BASE  = 4'd10;
	localparam logic [3:0] TDOA_UNIT_BASE = 4'd4;
	localparam logic [3:0] TDOA_STEP_BASE = 4'd7;
	localparam logic [3:0] COL_NONE       = 4'd13;
	localparam logic [3:0] COL_FILLED     = 4'd0;
	localparam logic [14:0] STEP_MAX      = 15'd32767;
	localparam logic [15:0] STEP_OFFSET   = 16'd2;

	localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
	localparam logic signed [31:0] AOA_LIMIT = 32'(longint'(30) << FRAC_BITS);
	localparam int DEV_SHIFT = 7; // divide by 128 is a floor shift
	localparam longint FILL_WIDE = longint'(1023) << FRAC_BITS;
	localparam logic signed [31:0] FILL_VALUE =
		(FILL_WIDE > longint'(2147483647)) ? VAL_MAX : 32'(FILL_WIDE);

	// unit latencies and pipeline stage numbers
	localparam int DIV_QW   = 32 + FRAC_BITS;
	localparam int DIV_LAT  = DIV_QW + 2;
	localparam int SQ_N     = 32;
	localparam int SQRT_LAT = SQ_N + 2;
	localparam int ST_SUM   = 3;
	localparam int ST_SQ    = ST_SUM + SQRT_LAT;
	localparam int ST_DQ    = ST_SQ + DIV_LAT;
	localparam int ST_SD2   = ST_DQ + 2;

	typedef struct packed {
		logic [2:0]  out_row;
		logic [2:0]  src;
		logic        filled;
		logic        last;
		logic [14:0] step_term;
	} meta_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] x;
		logic signed [31:0] y;
		meta_t              meta;
	} row_task_t;

endpackage
`default_nettype wire

FILE: hdl/ajr_if.sv
// Interfaces: request channel and result channel.
`default_nettype none
interface ajr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [14:0]        step_number;
	logic [5:0]         valid_mask;
	logic [1:0]         aoa_count;
	logic [1:0]         tdoa_count;
	modport source (output valid, pos_x, pos_y, step_number, valid_mask, aoa_count,
		tdoa_count, input ready);
	modport sink (input valid, pos_x, pos_y, step_number, valid_mask, aoa_count,
		tdoa_count, output ready);
endinterface

interface ajr_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         out_row;
	logic [2:0]         source_row;
	logic signed [31:0] col0_value;
	logic signed [31:0] col1_value;
	logic [3:0]         unit_column;
	logic [3:0]         step_column;
	logic [14:0]        step_term;
	logic               row_filled;
	logic               last_row;
	modport source (output valid, out_row, source_row, col0_value, col1_value,
		unit_column, step_column, step_term, row_filled, last_row, input ready);
	modport sink (input valid, out_row, source_row, col0_value, col1_value,
		unit_column, step_column, step_term, row_filled, last_row, output ready);
endinterface
`default_nettype wire

FILE: hdl/ajr_div.sv
// Pipelined floor divider: (a << FRAC_BITS) / b, one quotient bit per stage.
`default_nettype none
module ajr_div (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [31:0]      q
);
	import ajr_pkg::*;

	logic [31:0]       rem_s [0:DIV_QW];
	logic [DIV_QW-1:0] nq_s  [0:DIV_QW];
	logic [31:0]       d_s   [0:DIV_QW-1];
	logic              neg_s [0:DIV_QW];
	logic              sa_s  [0:DIV_QW];
	logic              dz_s  [0:DIV_QW];
	logic [31:0]       rem_nx [1:DIV_QW];
	logic [DIV_QW-1:0] nq_nx  [1:DIV_QW];
	logic [31:0]       amag, bmag, qm;
	logic signed [31:0] q_nx;

	assign amag = a[31] ? 32'(-a) : 32'(a);
	assign bmag = b[31] ? 32'(-b) : 32'(b);

	always_comb begin
		logic [32:0] t;
		logic        ge;
		for (int k = 1; k <= DIV_QW; k++) begin
			t  = {rem_s[k-1], nq_s[k-1][DIV_QW-1]};
			ge = t >= {1'b0, d_s[k-1]};
			rem_nx[k] = ge ? 32'(t - {1'b0, d_s[k-1]}) : t[31:0];
			nq_nx[k]  = {nq_s[k-1][DIV_QW-2:0], ge};
		end
	end

	always_comb begin
		qm = nq_s[DIV_QW][31:0];
		if (dz_s[DIV_QW])
			q_nx = sa_s[DIV_QW] ? VAL_MIN : VAL_MAX;
		else if (neg_s[DIV_QW])
			q_nx = -qm - {31'd0, |rem_s[DIV_QW]};
		else
			q_nx = qm;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= {amag, {FRAC_BITS{1'b0}}};
			d_s[0]   <= bmag;
			neg_s[0] <= a[31] ^ b[31];
			sa_s[0]  <= a[31];
			dz_s[0]  <= (b == '0);
			for (int k = 1; k <= DIV_QW; k++) begin
				rem_s[k] <= rem_nx[k];
				nq_s[k]  <= nq_nx[k];
				neg_s[k] <= neg_s[k-1];
				sa_s[k]  <= sa_s[k-1];
				dz_s[k]  <= dz_s[k-1];
			end
			for (int k = 1; k < DIV_QW; k++)
				d_s[k] <= d_s[k-1];
			q <= q_nx;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/ajr_sqrt.sv
// Pipelined integer square root of a 64-bit value, saturated to 31 bits.
`default_nettype none
module ajr_sqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] v,
	output logic signed [31:0] r
);
	import ajr_pkg::*;

	logic [63:0] v_s    [0:SQ_N-1];
	logic [33:0] rem_s  [0:SQ_N];
	logic [31:0] root_s [0:SQ_N];
	logic [33:0] rem_nx  [1:SQ_N];
	logic [31:0] root_nx [1:SQ_N];

	always_comb begin
		logic [35:0] t, tr;
		logic        ge;
		for (int k = 1; k <= SQ_N; k++) begin
			t  = {rem_s[k-1], v_s[k-1][63:62]};
			tr = {2'b00, root_s[k-1], 2'b01};
			ge = t >= tr;
			rem_nx[k]  = ge ? 34'(t - tr) : t[33:0];
			root_nx[k] = {root_s[k-1][30:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s[0]    <= v;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			for (int k = 1; k <= SQ_N; k++) begin
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
			end
			for (int k = 1; k < SQ_N; k++)
				v_s[k] <= {v_s[k-1][61:0], 2'b00};
			r <= root_s[SQ_N][31] ? VAL_MAX : $signed(root_s[SQ_N]);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/ajr_sched.sv
// Row scheduler: holds one request and issues its emitted rows, one per cycle while en is high.
`default_nettype none
module ajr_sched (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	ajr_in_if.sink           in_ch,
	output ajr_pkg::row_task_t task_s0
);
	import ajr_pkg::*;

	logic               item_v_q;
	logic signed [31:0] x_q, y_q;
	logic [14:0]        step_q;
	logic [N_ROWS-1:0]  emit_q, fill_q;
	logic [2:0]         src_q [0:N_ROWS-1];

	logic [2:0]         src_n [0:N_ROWS-1];
	logic [N_ROWS-1:0]  emit_n, fill_n, rem_mask;
	logic [2:0]         cnt, sum, pick;
	logic               mismatch, last, accept;
	logic [15:0]        st_wide;
	logic [14:0]        step_n;

	// compaction of the incoming mask
	always_comb begin
		cnt = '0;
		for (int i = 0; i < N_ROWS; i++)
			src_n[i] = '0;
		for (int i = 0; i < N_ROWS; i++) begin
			if (in_ch.valid_mask[i]) begin
				src_n[cnt] = 3'(i);
				cnt = cnt + 3'd1;
			end
		end
		sum = {1'b0, in_ch.aoa_count} + {1'b0, in_ch.tdoa_count};
		mismatch = cnt != sum;
		for (int k = 0; k < N_ROWS; k++) begin
			fill_n[k] = mismatch && (3'(k) >= sum);
			emit_n[k] = (3'(k) < cnt) || fill_n[k];
		end
		st_wide = {1'b0, in_ch.step_number} + STEP_OFFSET;
		step_n  = (st_wide > {1'b0, STEP_MAX}) ? STEP_MAX : st_wide[14:0];
	end

	always_comb begin
		pick = '0;
		for (int k = N_ROWS - 1; k >= 0; k--)
			if (emit_q[k]) pick = 3'(k);
		rem_mask = emit_q & ~(N_ROWS'(1) << pick);
		last = rem_mask == '0;
	end

	assign in_ch.ready = !item_v_q || (en && last);
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
			task_s0  <= '0;
		end else begin
			if (en) begin
				task_s0.valid          <= item_v_q;
				task_s0.x              <= x_q;
				task_s0.y              <= y_q;
				task_s0.meta.out_row   <= pick;
				task_s0.meta.src       <= src_q[pick];
				task_s0.meta.filled    <= fill_q[pick];
				task_s0.meta.last      <= last;
				task_s0.meta.step_term <= step_q;
			end
			if (accept)
				item_v_q <= emit_n != '0;
			else if (en && item_v_q)
				item_v_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= in_ch.pos_x;
			y_q    <= in_ch.pos_y;
			step_q <= step_n;
			emit_q <= emit_n;
			fill_q <= fill_n;
			for (int k = 0; k < N_ROWS; k++)
				src_q[k] <= src_n[k];
		end else if (en && item_v_q) begin
			emit_q <= rem_mask;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/aoa_tdoa_jacobian_rows_core.sv
// Top level: AOA/TDOA Jacobian row generator with configuration registers.
//
// Use:
//  in_ch  - one request per position estimate: pos_x, pos_y, step_number,
//           valid_mask and the declared AOA/TDOA counts. Taken when valid
//           and ready are both high.
//  out_ch - one result row per transfer, compacted: out_row, source_row,
//           the two column values, unit/step columns, step_term, row_filled
//           and last_row (set on the final row of a request).
//  cfg_*  - write port for the six sensor coordinates and tdoa_scale;
//           write only while no request is in flight.
// Throughput: one row per cycle while out_ch is not stalled, set by the row
//  scheduler. A request holds it until every row it emits (1 to 6) is issued and
//  the next one is taken with its last row; a request that emits no row yields none.
// Pipeline: from request to its first row: the scheduler, 3 arithmetic stages,
//  a 34-stage square root, a (34 + FRAC_BITS)-stage floor divider (Q16.16),
//  2 combining stages and the output register.
// Reset: registers return to their reset values, all pipeline valid bits
//  clear, the block is ready at once.
// Stall: when out_ch holds a row and ready is low, the whole pipeline and
//  the scheduler freeze; nothing is lost or repeated.
`default_nettype none
module aoa_tdoa_jacobian_rows_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	ajr_in_if.sink           in_ch,
	ajr_out_if.source        out_ch
);
	import ajr_pkg::*;

	function automatic logic [63:0] sq64(input logic signed [31:0] a);
		logic signed [63:0] p;
		p = a * a;
		return p;
	endfunction

	// configuration registers
	logic signed [31:0] s1x_q, s1y_q, s2x_q, s2y_q, s3x_q, s3y_q, scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1x_q   <= RST_SENSOR1_X;
			s1y_q   <= RST_SENSOR1_Y;
			s2x_q   <= RST_SENSOR2_X;
			s2y_q   <= RST_SENSOR2_Y;
			s3x_q   <= RST_SENSOR3_X;
			s3y_q   <= RST_SENSOR3_Y;
			scale_q <= RST_TDOA_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSOR1_X:  s1x_q   <= cfg_data;
				REG_SENSOR1_Y:  s1y_q   <= cfg_data;
				REG_SENSOR2_X:  s2x_q   <= cfg_data;
				REG_SENSOR2_Y:  s2y_q   <= cfg_data;
				REG_SENSOR3_X:  s3x_q   <= cfg_data;
				REG_SENSOR3_Y:  s3y_q   <= cfg_data;
				REG_TDOA_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the output register is free or being drained
	logic ov_q, en;
	assign en = !ov_q || out_ch.ready;

	row_task_t task_s0;

	ajr_sched u_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ch   (in_ch),
		.task_s0 (task_s0)
	);

	// control travelling alongside the data
	logic  vld_s  [1:ST_SD2];
	meta_t meta_s [1:ST_SD2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_SD2; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= task_s0.valid;
			for (int k = 2; k <= ST_SD2; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[1] <= task_s0.meta;
			for (int k = 2; k <= ST_SD2; k++)
				meta_s[k] <= meta_s[k-1];
		end
	end

	// sensor selection: sensor a for AOA rows and first of a TDOA pair
	logic signed [31:0] sax, say, sbx, sby;
	always_comb begin
		case (task_s0.meta.src)
			ROW_AOA2, ROW_TDOA23: begin sax = s2x_q; say = s2y_q; end
			ROW_AOA3:             begin sax = s3x_q; say = s3y_q; end
			default:              begin sax = s1x_q; say = s1y_q; end
		endcase
		case (task_s0.meta.src)
			ROW_TDOA13, ROW_TDOA23: begin sbx = s3x_q; sby = s3y_q; end
			default:                begin sbx = s2x_q; sby = s2y_q; end
		endcase
	end

	// s1: differences
	logic signed [31:0] dx_s1, dy_s1;
	logic signed [31:0] exa_s [1:ST_SQ];
	logic signed [31:0] eya_s [1:ST_SQ];
	logic signed [31:0] exb_s [1:ST_SQ];
	logic signed [31:0] eyb_s [1:ST_SQ];

	// s2: AOA scaling, TDOA squares
	logic               dev;
	logic signed [31:0] tx, ty, ntx;
	logic signed [31:0] tx_s2, ty_s2;
	logic signed [31:0] ty2_s  [2:ST_SQ];
	logic signed [31:0] ntx2_s [2:ST_SQ];
	logic [63:0]        sqxa_s2, sqya_s2, sqxb_s2, sqyb_s2;

	always_comb begin
		dev = (dx_s1 > AOA_LIMIT) || (dx_s1 < -AOA_LIMIT) ||
		      (dy_s1 > AOA_LIMIT) || (dy_s1 < -AOA_LIMIT);
		tx  = dev ? (dx_s1 >>> DEV_SHIFT) : dx_s1;
		ty  = dev ? (dy_s1 >>> DEV_SHIFT) : dy_s1;
		ntx = -tx;
	end

	// s3: AOA squares, TDOA squared norms; s4: AOA denominator
	logic [63:0]        txsq_s3, tysq_s3, suma_s3, sumb_s3, aoa_sum;
	logic signed [31:0] num_s [4:ST_SQ];
	assign aoa_sum = txsq_s3 + tysq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= sax - task_s0.x;
			dy_s1    <= say - task_s0.y;
			exa_s[1] <= task_s0.x - sax;
			eya_s[1] <= task_s0.y - say;
			exb_s[1] <= task_s0.x - sbx;
			eyb_s[1] <= task_s0.y - sby;
			for (int k = 2; k <= ST_SQ; k++) begin
				exa_s[k] <= exa_s[k-1];
				eya_s[k] <= eya_s[k-1];
				exb_s[k] <= exb_s[k-1];
				eyb_s[k] <= eyb_s[k-1];
			end

			tx_s2     <= tx;
			ty_s2     <= ty;
			ty2_s[2]  <= dev ? (ty >>> DEV_SHIFT) : ty;
			ntx2_s[2] <= dev ? (ntx >>> DEV_SHIFT) : ntx;
			for (int k = 3; k <= ST_SQ; k++) begin
				ty2_s[k]  <= ty2_s[k-1];
				ntx2_s[k] <= ntx2_s[k-1];
			end
			sqxa_s2 <= sq64(exa_s[1]);
			sqya_s2 <= sq64(eya_s[1]);
			sqxb_s2 <= sq64(exb_s[1]);
			sqyb_s2 <= sq64(eyb_s[1]);

			txsq_s3 <= sq64(tx_s2);
			tysq_s3 <= sq64(ty_s2);
			suma_s3 <= sqxa_s2 + sqya_s2;
			sumb_s3 <= sqxb_s2 + sqyb_s2;

			num_s[4] <= aoa_sum[FRAC_BITS +: 32];
			for (int k = 5; k <= ST_SQ; k++)
				num_s[k] <= num_s[k-1];
		end
	end

	// norms to the two sensors
	logic signed [31:0] ra, rb;
	ajr_sqrt u_sqrt_a (.clk(clk), .en(en), .v(suma_s3), .r(ra));
	ajr_sqrt u_sqrt_b (.clk(clk), .en(en), .v(sumb_s3), .r(rb));

	// dividers: AOA rows borrow the first two
	logic               tdoa_sq;
	logic signed [31:0] d0a, d1a, d01b, q0, q1, q2, q3;
	assign tdoa_sq = meta_s[ST_SQ].src >= ROW_TDOA12;
	assign d0a     = tdoa_sq ? exa_s[ST_SQ] : ty2_s[ST_SQ];
	assign d1a     = tdoa_sq ? eya_s[ST_SQ] : ntx2_s[ST_SQ];
	assign d01b    = tdoa_sq ? ra : num_s[ST_SQ];

	ajr_div u_div0 (.clk(clk), .en(en), .a(d0a),          .b(d01b), .q(q0));
	ajr_div u_div1 (.clk(clk), .en(en), .a(d1a),          .b(d01b), .q(q1));
	ajr_div u_div2 (.clk(clk), .en(en), .a(exb_s[ST_SQ]), .b(rb),   .q(q2));
	ajr_div u_div3 (.clk(clk), .en(en), .a(eyb_s[ST_SQ]), .b(rb),   .q(q3));

	// sd1/sd2: stages after the divider - difference, then scale product
	logic signed [31:0] dfx_sd1, dfy_sd1, c0_sd1, c1_sd1, c0_sd2, c1_sd2;
	logic signed [63:0] px_sd2, py_sd2;

	always_ff @(posedge clk) begin
		if (en) begin
			dfx_sd1 <= q0 - q2;
			dfy_sd1 <= q1 - q3;
			c0_sd1  <= q0;
			c1_sd1  <= q1;
			px_sd2  <= scale_q * dfx_sd1;
			py_sd2  <= scale_q * dfy_sd1;
			c0_sd2  <= c0_sd1;
			c1_sd2  <= c1_sd1;
		end
	end

	// output register
	meta_t              mo;
	logic               tdoa_o;
	logic signed [31:0] c0_n, c1_n;
	logic [3:0]         ucol_n, scol_n;
	logic [2:0]         orow_q, osrc_q;
	logic signed [31:0] c0_q, c1_q;
	logic [3:0]         ucol_q, scol_q;
	logic [14:0]        sterm_q;
	logic               ofill_q, olast_q;

	assign mo     = meta_s[ST_SD2];
	assign tdoa_o = mo.src >= ROW_TDOA12;

	always_comb begin
		if (mo.filled) begin
			c0_n   = FILL_VALUE;
			c1_n   = FILL_VALUE;
			ucol_n = COL_FILLED;
			scol_n = COL_NONE;
		end else if (tdoa_o) begin
			c0_n   = px_sd2[FRAC_BITS +: 32];
			c1_n   = py_sd2[FRAC_BITS +: 32];
			ucol_n = TDOA_UNIT_BASE + {1'b0, mo.src} - {1'b0, ROW_TDOA12};
			scol_n = TDOA_STEP_BASE + {1'b0, mo.src} - {1'b0, ROW_TDOA12};
		end else begin
			c0_n   = c0_sd2;
			c1_n   = c1_sd2;
			ucol_n = AOA_UNIT_BASE + {1'b0, mo.src};
			scol_n = COL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (en)
			ov_q <= vld_s[ST_SD2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			orow_q  <= mo.out_row;
			osrc_q  <= mo.src;
			c0_q    <= c0_n;
			c1_q    <= c1_n;
			ucol_q  <= ucol_n;
			scol_q  <= scol_n;
			sterm_q <= mo.step_term;
			ofill_q <= mo.filled;
			olast_q <= mo.last;
		end
	end

	assign out_ch.valid       = ov_q;
	assign out_ch.out_row     = orow_q;
	assign out_ch.source_row  = osrc_q;
	assign out_ch.col0_value  = c0_q;
	assign out_ch.col1_value  = c1_q;
	assign out_ch.unit_column = ucol_q;
	assign out_ch.step_column = scol_q;
	assign out_ch.step_term   = sterm_q;
	assign out_ch.row_filled  = ofill_q;
	assign out_ch.last_row    = olast_q;

	// a stall freezes the pipeline entry
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[1]))
		else $error("pipeline moved during stall");

	a_fill_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.row_filled |->
		out_ch.col0_value == FILL_VALUE && out_ch.col1_value == FILL_VALUE &&
		out_ch.unit_column == COL_FILLED && out_ch.step_column == COL_NONE)
		else $error("filled row carries wrong entries");

	a_tdoa_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.row_filled && out_ch.source_row >= ROW_TDOA12 |->
		out_ch.step_column == out_ch.unit_column + 4'd3)
		else $error("TDOA row columns inconsistent");

endmodule
`default_nettype wire
